FILE: rtl/rrarb_pkg.sv
// ----------------------------------------------------------------------------
// rrarb_pkg
// Shared types and constants of the two-level round-robin L2 path arbiter.
// ----------------------------------------------------------------------------
package rrarb_pkg;

   localparam int REQ_CORES     = 4;
   localparam int CORE_W        = 2;
   localparam int REQ_W         = 2 * REQ_CORES;
   localparam int ACTIVE_W      = 3;
   localparam int NUM_CORES_DEF = 4;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET      = 3'd4;
   localparam logic [CORE_W-1:0]   TOKEN_CORE_RESET  = 2'd1;
   localparam logic [ACTIVE_W-1:0] MIN_CORES         = 3'd2;

   localparam logic CACHE_INSTR = 1'b0;
   localparam logic CACHE_DATA  = 1'b1;

   typedef struct packed {
      logic [REQ_W-1:0] request_bits;
      logic             l2_release;
      logic             l2_reject;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [CORE_W-1:0] core;
      logic              cache;
   } scan_type;

   typedef struct packed {
      logic              grant_valid;
      logic [CORE_W-1:0] grant_core;
      logic              grant_cache;
      logic              holder_release;
      logic              l2_request_active;
      logic              busy_res;
   } rsp_type;

endpackage

FILE: rtl/rrarb_in_reg.sv
// ----------------------------------------------------------------------------
// rrarb_in_reg
// Input register: captures one request per cycle while empty or advancing, frees itself as it advances.
// ----------------------------------------------------------------------------
module rrarb_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrarb_pkg::req_type req_data,
   input  logic              advance,
   output logic              s1_valid,
   output rrarb_pkg::req_type s1_data
);

   logic               valid_ff;
   logic               valid_in;
   rrarb_pkg::req_type data_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_data  = data_ff;

endmodule

FILE: rtl/rrarb_scan.sv
// ----------------------------------------------------------------------------
// rrarb_scan
// Rotating priority search from the token holder: following cores first,
// instruction before data, then the holder's other cache, then its own.
// ----------------------------------------------------------------------------
module rrarb_scan #(
   parameter int NUM_CORES = rrarb_pkg::NUM_CORES_DEF
) (
   input  logic [rrarb_pkg::REQ_W-1:0]  request_bits,
   input  logic [rrarb_pkg::CORE_W-1:0] token_core,
   input  logic                         token_cache,
   input  logic [((($clog2(NUM_CORES+1)) > rrarb_pkg::ACTIVE_W) ?
                  $clog2(NUM_CORES+1) : rrarb_pkg::ACTIVE_W)-1:0] core_count,
   output rrarb_pkg::scan_type          scan
);

   localparam int NW = ($clog2(NUM_CORES+1) > rrarb_pkg::ACTIVE_W) ?
                       $clog2(NUM_CORES+1) : rrarb_pkg::ACTIVE_W;

   logic [NW-1:0] c_ext;
   logic [NW-1:0] base;
   logic [NW-1:0] rot_gap [rrarb_pkg::REQ_CORES];
   logic          in_rot [rrarb_pkg::REQ_CORES];
   logic          own_other;
   logic          own_same;

   assign c_ext     = NW'(token_core);
   assign base      = (c_ext >= core_count) ? (c_ext - core_count) : c_ext;
   assign own_other = request_bits[{token_core, ~token_cache}];
   assign own_same  = request_bits[{token_core, token_cache}];

   always_comb begin
      for (int i = 0; i < rrarb_pkg::REQ_CORES; i++) begin
         in_rot[i]  = (NW'(i) < core_count) && (NW'(i) != base) &&
                      (|request_bits[2*i +: 2]);
         rot_gap[i] = (NW'(i) > base) ? (NW'(i) - base) : ((core_count - base) + NW'(i));
      end
   end

   always_comb begin
      logic                         rot_found;
      logic [NW-1:0]                best_gap;
      logic [rrarb_pkg::CORE_W-1:0] best_core;
      rot_found = 1'b0;
      best_gap  = '0;
      best_core = '0;
      for (int i = 0; i < rrarb_pkg::REQ_CORES; i++) begin
         if (in_rot[i] && (!rot_found || (rot_gap[i] < best_gap))) begin
            rot_found = 1'b1;
            best_gap  = rot_gap[i];
            best_core = rrarb_pkg::CORE_W'(i);
         end
      end
      scan = '0;
      priority if (rot_found) begin
         scan.found = 1'b1;
         scan.core  = best_core;
         scan.cache = request_bits[{best_core, rrarb_pkg::CACHE_INSTR}] ?
                      rrarb_pkg::CACHE_INSTR : rrarb_pkg::CACHE_DATA;
      end else if (own_other) begin
         scan.found = 1'b1;
         scan.core  = token_core;
         scan.cache = ~token_cache;
      end else if (own_same) begin
         scan.found = 1'b1;
         scan.core  = token_core;
         scan.cache = token_cache;
      end else begin
         scan.found = 1'b0;
      end
   end

endmodule

FILE: rtl/two_level_round_robin_bus_arbiter.sv
// ----------------------------------------------------------------------------
// two_level_round_robin_bus_arbiter
// Grants the shared L2 path to one core cache at a time, round robin over
// cores and caches, and holds the grant until L2 releases or rejects it.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | request_bits, l2_release, l2_reject
//   rsp     | out       | rsp_valid/rsp_ready  | grant, holder, release, active, busy
//   csr     | in        | csr_valid/csr_ready  | active_cores
//
// One request per cycle sustained while results are taken; a request passes the
// input register, then scan and token update into the result register.
// Token and wait state change only as a request moves into the result register.
// A stalled result holds; the input register still takes one more request.
// Reset: token core 1, data cache, not waiting, active_cores 4.
// ----------------------------------------------------------------------------
module two_level_round_robin_bus_arbiter #(
   parameter int NUM_CORES = rrarb_pkg::NUM_CORES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rrarb_pkg::REQ_W-1:0]    req_request_bits,
   input  logic                           req_l2_release,
   input  logic                           req_l2_reject,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_grant_valid,
   output logic [rrarb_pkg::CORE_W-1:0]   rsp_grant_core,
   output logic                           rsp_grant_cache,
   output logic                           rsp_holder_release,
   output logic                           rsp_l2_request_active,
   output logic                           rsp_busy_res,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrarb_pkg::ACTIVE_W-1:0] csr_active_cores
);

   localparam int NW = ($clog2(NUM_CORES+1) > rrarb_pkg::ACTIVE_W) ?
                       $clog2(NUM_CORES+1) : rrarb_pkg::ACTIVE_W;

   rrarb_pkg::req_type  req_data;
   rrarb_pkg::req_type  s1_data;
   rrarb_pkg::scan_type scan;
   rrarb_pkg::rsp_type  rsp_ff;
   rrarb_pkg::rsp_type  rsp_in;

   logic                           s1_valid;
   logic                           advance;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [rrarb_pkg::ACTIVE_W-1:0] active_ff;
   logic [rrarb_pkg::CORE_W-1:0]   token_core_ff;
   logic [rrarb_pkg::CORE_W-1:0]   token_core_in;
   logic                           token_cache_ff;
   logic                           token_cache_in;
   logic                           busy_ff;
   logic                           busy_in;
   logic [NW-1:0]                  active_ext;
   logic [NW-1:0]                  core_count;

   assign req_data.request_bits = req_request_bits;
   assign req_data.l2_release   = req_l2_release;
   assign req_data.l2_reject    = req_l2_reject;

   rrarb_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data)
   );

   assign active_ext = NW'(active_ff);

   always_comb begin
      priority if (active_ext < NW'(rrarb_pkg::MIN_CORES)) begin
         core_count = NW'(rrarb_pkg::MIN_CORES);
      end else if (active_ext > NW'(NUM_CORES)) begin
         core_count = NW'(NUM_CORES);
      end else begin
         core_count = active_ext;
      end
   end

   rrarb_scan #(
      .NUM_CORES (NUM_CORES)
   ) u_scan (
      .request_bits (s1_data.request_bits),
      .token_core   (token_core_ff),
      .token_cache  (token_cache_ff),
      .core_count   (core_count),
      .scan         (scan)
   );

   assign advance      = s1_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      logic keep;
      keep           = !s1_data.l2_release && !s1_data.l2_reject;
      token_core_in  = token_core_ff;
      token_cache_in = token_cache_ff;
      busy_in        = busy_ff;
      rsp_in         = '0;
      if (busy_ff) begin
         busy_in                  = keep;
         rsp_in.holder_release    = s1_data.l2_release && !s1_data.l2_reject;
         rsp_in.l2_request_active = keep;
      end else if (scan.found) begin
         token_core_in            = scan.core;
         token_cache_in           = scan.cache;
         busy_in                  = 1'b1;
         rsp_in.grant_valid       = 1'b1;
         rsp_in.l2_request_active = 1'b1;
      end
      rsp_in.grant_core  = token_core_in;
      rsp_in.grant_cache = token_cache_in;
      rsp_in.busy_res    = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_core_ff  <= rrarb_pkg::TOKEN_CORE_RESET;
         token_cache_ff <= rrarb_pkg::CACHE_DATA;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         active_ff      <= rrarb_pkg::ACTIVE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            token_core_ff  <= token_core_in;
            token_cache_ff <= token_cache_in;
            busy_ff        <= busy_in;
         end
         if (csr_valid && csr_ready) begin
            active_ff <= csr_active_cores;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_grant_valid       = rsp_ff.grant_valid;
   assign rsp_grant_core        = rsp_ff.grant_core;
   assign rsp_grant_cache       = rsp_ff.grant_cache;
   assign rsp_holder_release    = rsp_ff.holder_release;
   assign rsp_l2_request_active = rsp_ff.l2_request_active;
   assign rsp_busy_res          = rsp_ff.busy_res;

`ifndef SYNTHESIS
   a_grant_only_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.grant_valid) |-> !busy_ff)
      else $error("grant issued while waiting on L2");

   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_busy_res == busy_ff))
      else $error("busy result out of step with wait state");

   a_active_eq_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_l2_request_active == rsp_busy_res))
      else $error("L2 request level disagrees with busy");

   a_no_grant_and_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_grant_valid && rsp_holder_release))
      else $error("grant and release in the same request");

   a_token_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(token_core_ff) && $stable(token_cache_ff) && $stable(busy_ff)))
      else $error("token moved without a request");
`endif

endmodule

FILE: tb/sv/tb_two_level_round_robin_bus_arbiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_level_round_robin_bus_arbiter
// Self-checking bench for the two-level round-robin L2 path arbiter.
// A short table of directed requests is followed by random phases, each with
// its own core count and idle pattern. Every request is run through a local
// token scan model; results are checked in order against it or typed rows.
// ----------------------------------------------------------------------------
module tb_two_level_round_robin_bus_arbiter;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_LEN      = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 10;
   localparam int PHASE_ITEMS   = 100;
   localparam int REPORT_MAX    = 10;

   typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [rrarb_pkg::ACTIVE_W-1:0] cfg;
      logic [rrarb_pkg::REQ_W-1:0]    bits;
      logic                           rel;
      logic                           rej;
      logic                           typed;
      rrarb_pkg::rsp_type             exp;
   } dir_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [rrarb_pkg::REQ_W-1:0]    req_request_bits = '0;
   logic                           req_l2_release = 1'b0;
   logic                           req_l2_reject = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_grant_valid;
   logic [rrarb_pkg::CORE_W-1:0]   rsp_grant_core;
   logic                           rsp_grant_cache;
   logic                           rsp_holder_release;
   logic                           rsp_l2_request_active;
   logic                           rsp_busy_res;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [rrarb_pkg::ACTIVE_W-1:0] csr_active_cores = rrarb_pkg::ACTIVE_RESET;

   // model state
   int                             tok_core;
   logic                           tok_cache;
   logic                           busy;
   logic [rrarb_pkg::ACTIVE_W-1:0] active;

   rrarb_pkg::rsp_type             awaited_rsp [$];
   dir_row_type                    dir_rows [$];
   int                             send_pct = 0;
   int                             stall_pct = 0;
   logic                           pressure_on = 1'b0;
   int                             hold_cnt = 0;
   int                             cycle_count = 0;
   int                             errors = 0;
   int                             requests_sent = 0;
   int                             grants_seen = 0;
   int                             releases_seen = 0;
   int                             cfg_writes = 0;

   two_level_round_robin_bus_arbiter dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_request_bits      (req_request_bits),
      .req_l2_release        (req_l2_release),
      .req_l2_reject         (req_l2_reject),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_grant_valid       (rsp_grant_valid),
      .rsp_grant_core        (rsp_grant_core),
      .rsp_grant_cache       (rsp_grant_cache),
      .rsp_holder_release    (rsp_holder_release),
      .rsp_l2_request_active (rsp_l2_request_active),
      .rsp_busy_res          (rsp_busy_res),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_active_cores      (csr_active_cores)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic has_req(logic [rrarb_pkg::REQ_W-1:0] bits, int core, int cache);
      if (core >= rrarb_pkg::REQ_CORES || 2 * core + cache >= rrarb_pkg::REQ_W) return 1'b0;
      return bits[2 * core + cache];
   endfunction

   function automatic rrarb_pkg::rsp_type arbitrate(logic [rrarb_pkg::REQ_W-1:0] bits,
                                                    logic rel, logic rej);
      rrarb_pkg::rsp_type r;
      int                 n;
      int                 base;
      int                 core;
      int                 d;
      int                 j;
      int                 win_core;
      logic               win_cache;
      logic               found;
      r = '0;
      if (busy) begin
         r.holder_release    = rel & ~rej;
         r.l2_request_active = ~rel & ~rej;
         busy                = ~rel & ~rej;
      end else begin
         n = int'(active);
         if (n < int'(rrarb_pkg::MIN_CORES)) n = int'(rrarb_pkg::MIN_CORES);
         if (n > rrarb_pkg::NUM_CORES_DEF) n = rrarb_pkg::NUM_CORES_DEF;
         base      = tok_core % n;
         found     = 1'b0;
         win_core  = 0;
         win_cache = rrarb_pkg::CACHE_INSTR;
         for (d = 1; d < n && !found; d++) begin
            core = (base + d) % n;
            for (j = 0; j < 2 && !found; j++) begin
               if (has_req(bits, core, j)) begin
                  found     = 1'b1;
                  win_core  = core;
                  win_cache = j[0];
               end
            end
         end
         // own core: other cache first, same cache last
         if (!found && has_req(bits, tok_core, int'(!tok_cache))) begin
            found     = 1'b1;
            win_core  = tok_core;
            win_cache = ~tok_cache;
         end
         if (!found && has_req(bits, tok_core, int'(tok_cache))) begin
            found     = 1'b1;
            win_core  = tok_core;
            win_cache = tok_cache;
         end
         if (found) begin
            tok_core            = win_core;
            tok_cache           = win_cache;
            busy                = 1'b1;
            r.grant_valid       = 1'b1;
            r.l2_request_active = 1'b1;
         end
      end
      r.grant_core  = tok_core[rrarb_pkg::CORE_W-1:0];
      r.grant_cache = tok_cache;
      r.busy_res    = busy;
      return r;
   endfunction

   task automatic offer(logic [rrarb_pkg::REQ_W-1:0] bits, logic rel, logic rej,
                        logic typed, rrarb_pkg::rsp_type exp);
      rrarb_pkg::rsp_type p;
      req_valid        <= 1'b1;
      req_request_bits <= bits;
      req_l2_release   <= rel;
      req_l2_reject    <= rej;
      do @(posedge clock); while (!req_ready);
      p = arbitrate(bits, rel, rej);
      awaited_rsp.push_back(typed ? exp : p);
      requests_sent++;
      if (p.grant_valid) grants_seen++;
      if (p.holder_release) releases_seen++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [rrarb_pkg::ACTIVE_W-1:0] v);
      csr_active_cores <= v;
      csr_valid        <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active = v;
      cfg_writes++;
   endtask

   task automatic set_idle(idle_mode_type m);
      send_pct  = (m == IDLE_SEND) ? 49 : (m == IDLE_BOTH) ? 35 : 0;
      stall_pct = (m == IDLE_RECV) ? 49 : (m == IDLE_BOTH) ? 35 : 0;
   endtask

   // receiver: random stalls, plus one long hold-off under pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= 0;
      end else if (pressure_on && hold_cnt < HOLD_LEN) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (!pressure_on) hold_cnt <= 0;
      end
   end

   always @(posedge clock) begin
      rrarb_pkg::rsp_type got;
      rrarb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_grant_valid, rsp_grant_core, rsp_grant_cache, rsp_holder_release,
                rsp_l2_request_active, rsp_busy_res};
         if (awaited_rsp.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("ERROR: unexpected result %b at cycle %0d", got, cycle_count);
         end else begin
            want = awaited_rsp.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display({"ERROR: cycle %0d gv/core/cache/rel/act/busy ",
                            "exp %b/%0d/%b/%b/%b/%b got %b/%0d/%b/%b/%b/%b"},
                           cycle_count, want.grant_valid, want.grant_core,
                           want.grant_cache, want.holder_release,
                           want.l2_request_active, want.busy_res, got.grant_valid,
                           got.grant_core, got.grant_cache, got.holder_release,
                           got.l2_request_active, got.busy_res);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d results outstanding", awaited_rsp.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [rrarb_pkg::REQ_W-1:0]    bits;
      logic                           rel;
      logic                           rej;
      int                             idle;
      int                             sel;
      logic [rrarb_pkg::ACTIVE_W-1:0] cfg_seq [8];
      cfg_seq = '{3'd4, 3'd2, 3'd3, 3'd0, 3'd1, 3'd5, 3'd7, 3'd6};

      tok_core  = int'(rrarb_pkg::TOKEN_CORE_RESET);
      tok_cache = rrarb_pkg::CACHE_DATA;
      busy      = 1'b0;
      active    = rrarb_pkg::ACTIVE_RESET;
      set_idle(IDLE_NONE);

      // kind, cfg, bits, release, reject, typed, expected gv/core/cache/rel/act/busy
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b1, 1'b1,
                           {1'b0, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0}});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h02, 1'b0, 1'b0, 1'b1,
                           {1'b1, 2'd0, 1'b1, 1'b0, 1'b1, 1'b1}});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'hFF, 1'b0, 1'b0, 1'b1,
                           {1'b0, 2'd0, 1'b1, 1'b0, 1'b1, 1'b1}});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'hFF, 1'b1, 1'b1, 1'b1,
                           {1'b0, 2'd0, 1'b1, 1'b0, 1'b0, 1'b0}});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'hFF, 1'b0, 1'b0, 1'b1,
                           {1'b1, 2'd1, 1'b0, 1'b0, 1'b1, 1'b1}});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b1,
                           {1'b0, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0}});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h01, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b0, 1'b1, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h01, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h03, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h80, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'hC0, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0});
      // token core beyond a core count of two
      dir_rows.push_back('{ROW_CFG, 3'd2, 8'h00, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'hC0, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_CFG, 3'd0, 8'h00, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'hFF, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_CFG, 3'd7, 8'h00, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h30, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{ROW_REQ, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            settle();
            write_csr(dir_rows[i].cfg);
         end else begin
            offer(dir_rows[i].bits, dir_rows[i].rel, dir_rows[i].rej, dir_rows[i].typed,
                  dir_rows[i].exp);
         end
      end

      for (int p = 0; p < 8; p++) begin
         settle();
         write_csr(cfg_seq[p]);
         set_idle(idle_mode_type'(p % 4));
         if (p == 0) pressure_on <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 0 && i == 40) pressure_on <= 1'b0;
            idle = 0;
            while ($urandom_range(99) < send_pct) idle++;
            if (idle > 0) begin
               req_valid <= 1'b0;
               repeat (idle) @(posedge clock);
            end
            sel = $urandom_range(7);
            case (sel)
               0: begin
                  bits = '0;
               end
               1, 2: begin
                  bits = '0;
                  bits[$urandom_range(rrarb_pkg::REQ_W - 1)] = 1'b1;
               end
               3: begin
                  bits = '1;
               end
               default: begin
                  bits = rrarb_pkg::REQ_W'($urandom_range(255));
               end
            endcase
            rel = ($urandom_range(3) == 0);
            rej = ($urandom_range(5) == 0);
            offer(bits, rel, rej, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Summary: %0d requests, %0d grants, %0d holder releases, %0d errors",
               requests_sent, grants_seen, releases_seen, errors);
      $display("Covered core counts 0 to 7 in %0d writes, four idle patterns, one hold-off",
               cfg_writes);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
